// File: rtl/bbrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbrt_pkg;

   localparam int BINS  = 10;
   localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int IDX_W = 4;
   localparam int LVL_W = 16;
   localparam int TIME_W = 64;
   localparam int DIV_W = LVL_W + BIN_W;
   localparam int STEP_W = $clog2(BIN_W + 1);

   // packed stream words, first field in the lowest bits, padded to bytes
   localparam int REQ_W = 88;
   localparam int RSP_W = 72;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] MODE_BRIGHT = 2'd0;
   localparam logic [1:0] MODE_POWER  = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [2:0] PWR_ON  = 3'd0;
   localparam logic [2:0] PWR_OFF = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_CLAMP  = 2'd1;
   localparam logic [1:0] ST_BADPWR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX = 2'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_BRIGHT,
      S_CRD,
      S_CDIFF,
      S_CSUM,
      S_RRD,
      S_RDIFF,
      S_RSUM,
      S_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic       load;
      logic       div_init;
      logic       div_step;
      logic       rd_en;
      logic       rd_cur;
      logic       diff_en;
      logic       diff_gate;
      logic       tot_wr;
      logic       start_new;
      logic       start_cur;
      logic       set_bin;
      logic       clr_known;
      logic       set_on;
      logic       clr_on;
      logic       clear_all;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       out_load;
      logic       out_read;
      logic [1:0] out_code;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] pv;
      logic       panel_on;
      logic       bin_known;
      logic       bin_change;
      logic       clamped;
      logic       out_free;
      logic       cnt_last;
   } dp_sts_type;

endpackage

`default_nettype wire

// File: rtl/brightness_bin_residency_timer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             payload
// req_     in   req_tvalid/tready     tdata: mode, brightness, power_value, now_ns
// rsp_     out  rsp_tvalid/tready     tdata: status, bin_index, bin_time; tlast: last
// csr_     in   csr_valid/csr_ready   csr_index, csr_data
//
// one word at a time: a brightness event runs the restoring divider, which retires one
// quotient bit a cycle, and may close an interval; a power event may close one too, and
// a read returns one word per bin through the single bin store port.
// synchronous reset clears all totals at once through per-bin valid bits, no sweep.
// the result register frees the core once loaded; a stalled rsp_ side holds the next one.

module brightness_bin_residency_timer_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // mode[1:0], brightness[17:2], power_value[20:18], now_ns[84:21], zero pad
   input  wire logic [bbrt_pkg::REQ_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // status[1:0], bin_index[5:2], bin_time[69:6], zero pad
   output logic [bbrt_pkg::RSP_W-1:0]          rsp_tdata,
   output logic                                rsp_tlast,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bbrt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bbrt_pkg::LVL_W-1:0]     csr_data
);

   bbrt_pkg::dp_cmd_type cmd;
   bbrt_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   bbrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbrt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

// File: rtl/bbrt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bbrt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire bbrt_pkg::dp_sts_type sts,
   output bbrt_pkg::dp_cmd_type      cmd
);

   bbrt_pkg::ctl_state_type state_ff, state_in;
   logic [bbrt_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0] code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbrt_pkg::S_IDLE;
         step_ff  <= '0;
         code_ff  <= bbrt_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      code_in    = code_ff;
      cmd        = '0;
      req_tready = 1'b0;
      cmd.out_code = code_ff;
      unique case (state_ff)
         bbrt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = bbrt_pkg::S_DECODE;
            end
         end
         bbrt_pkg::S_DECODE: begin
            code_in = bbrt_pkg::ST_OK;
            unique case (sts.mode)
               bbrt_pkg::MODE_BRIGHT: begin
                  cmd.div_init = 1'b1;
                  step_in  = '0;
                  state_in = bbrt_pkg::S_DIV;
               end
               bbrt_pkg::MODE_POWER: begin
                  priority if (sts.pv == bbrt_pkg::PWR_ON) begin
                     cmd.start_cur = !sts.panel_on && sts.bin_known;
                     cmd.set_on    = 1'b1;
                     state_in      = bbrt_pkg::S_EMIT;
                  end else if (sts.pv == bbrt_pkg::PWR_OFF) begin
                     cmd.clr_on = 1'b1;
                     if (sts.panel_on && sts.bin_known) begin
                        state_in = bbrt_pkg::S_CRD;
                     end else begin
                        state_in = bbrt_pkg::S_EMIT;
                     end
                  end else begin
                     code_in  = bbrt_pkg::ST_BADPWR;
                     state_in = bbrt_pkg::S_EMIT;
                  end
               end
               bbrt_pkg::MODE_READ: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = bbrt_pkg::S_RRD;
               end
               bbrt_pkg::MODE_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = bbrt_pkg::S_EMIT;
               end
            endcase
         end
         bbrt_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == bbrt_pkg::STEP_W'(bbrt_pkg::BIN_W - 1)) begin
               state_in = bbrt_pkg::S_BRIGHT;
            end
         end
         bbrt_pkg::S_BRIGHT: begin
            code_in = sts.clamped ? bbrt_pkg::ST_CLAMP : bbrt_pkg::ST_OK;
            if (sts.panel_on && (!sts.bin_known || sts.bin_change)) begin
               if (sts.bin_known) begin
                  state_in = bbrt_pkg::S_CRD;
               end else begin
                  cmd.start_new = 1'b1;
                  cmd.set_bin   = 1'b1;
                  state_in      = bbrt_pkg::S_EMIT;
               end
            end else begin
               cmd.set_bin = 1'b1;
               state_in    = bbrt_pkg::S_EMIT;
            end
         end
         // close the open interval of the current bin
         bbrt_pkg::S_CRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_cur = 1'b1;
            state_in   = bbrt_pkg::S_CDIFF;
         end
         bbrt_pkg::S_CDIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = bbrt_pkg::S_CSUM;
         end
         bbrt_pkg::S_CSUM: begin
            cmd.tot_wr = 1'b1;
            if (sts.mode == bbrt_pkg::MODE_BRIGHT) begin
               cmd.start_new = 1'b1;
               cmd.set_bin   = 1'b1;
            end else begin
               cmd.clr_known = 1'b1;
            end
            state_in = bbrt_pkg::S_EMIT;
         end
         // one word per bin
         bbrt_pkg::S_RRD: begin
            cmd.rd_en = 1'b1;
            state_in  = bbrt_pkg::S_RDIFF;
         end
         bbrt_pkg::S_RDIFF: begin
            cmd.diff_en   = 1'b1;
            cmd.diff_gate = 1'b1;
            state_in      = bbrt_pkg::S_RSUM;
         end
         bbrt_pkg::S_RSUM: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_read = 1'b1;
               cmd.out_code = bbrt_pkg::ST_OK;
               cmd.cnt_inc  = 1'b1;
               state_in = sts.cnt_last ? bbrt_pkg::S_IDLE : bbrt_pkg::S_RRD;
            end
         end
         bbrt_pkg::S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bbrt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bbrt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/bbrt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bbrt_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [bbrt_pkg::REQ_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bbrt_pkg::RSP_W-1:0]             rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_valid,
   input  wire logic [bbrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bbrt_pkg::LVL_W-1:0]        csr_data,
   input  wire bbrt_pkg::dp_cmd_type              cmd,
   output bbrt_pkg::dp_sts_type                   sts
);

   localparam int BW = bbrt_pkg::BIN_W;
   localparam int DW = bbrt_pkg::DIV_W;
   localparam int TW = bbrt_pkg::TIME_W;
   localparam int LW = bbrt_pkg::LVL_W;
   localparam int NB = bbrt_pkg::BINS;

   // configuration
   logic [LW-1:0] min_ff, min_in, max_ff, max_in;
   // latched item
   logic [1:0]    mode_ff, mode_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [2:0]    pv_ff, pv_in;
   logic [TW-1:0] now_ff, now_in;
   // divider
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [BW-1:0] q_ff, q_in;
   logic          clamp_ff, clamp_in;
   // bin state
   logic [BW-1:0] cur_ff, cur_in;
   logic          known_ff, known_in, on_ff, on_in;
   logic [BW-1:0] addr_ff, addr_in, cnt_ff, cnt_in;
   logic [TW-1:0] diff_ff, diff_in;
   logic [NB-1:0] tot_vld_ff, tot_vld_in, start_vld_ff, start_vld_in;
   // output word
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [bbrt_pkg::IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [TW-1:0] rsp_time_ff, rsp_time_in;
   logic          rsp_last_ff, rsp_last_in;

   // bin stores with registered reads
   logic [TW-1:0] tot_mem [NB];
   logic [TW-1:0] start_mem [NB];
   logic [TW-1:0] tot_rd_ff, start_rd_ff;

   logic [LW-1:0] hi, lvl_c, span;
   logic          clamped;
   logic [LW:0]   den_w;
   logic          ge, match, out_free;
   logic [BW-1:0] rd_a, start_a;
   logic          start_we;
   logic [TW-1:0] sum;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sum      = tot_rd_ff + diff_ff;
   assign match    = on_ff && known_ff && (cur_ff == addr_ff);
   assign rd_a     = cmd.rd_cur ? cur_ff : cnt_ff;
   assign start_a  = cmd.start_new ? q_ff : cur_ff;
   assign start_we = cmd.start_new || cmd.start_cur;
   assign ge       = rem_ff >= den_ff;

   // range, clamp and span of the bin division
   always_comb begin
      hi = (max_ff < min_ff) ? min_ff : max_ff;
      clamped = 1'b0;
      lvl_c   = lvl_ff;
      priority if (lvl_ff > hi) begin
         lvl_c   = hi;
         clamped = 1'b1;
      end else if (lvl_ff < min_ff) begin
         lvl_c   = min_ff;
         clamped = 1'b1;
      end
      span  = lvl_c - min_ff;
      den_w = {1'b0, hi} - {1'b0, min_ff} + 1'b1;
   end

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr_valid) begin
         if (csr_index == bbrt_pkg::CSR_MIN) begin
            min_in = csr_data;
         end else if (csr_index == bbrt_pkg::CSR_MAX) begin
            max_in = csr_data;
         end
      end

      mode_in = mode_ff;
      lvl_in  = lvl_ff;
      pv_in   = pv_ff;
      now_in  = now_ff;
      if (cmd.load) begin
         mode_in = req_tdata[1:0];
         lvl_in  = req_tdata[17:2];
         pv_in   = req_tdata[20:18];
         now_in  = req_tdata[84:21];
      end

      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      clamp_in = clamp_ff;
      if (cmd.div_init) begin
         rem_in   = DW'(span) * DW'(NB);
         den_in   = DW'(den_w) << (BW - 1);
         q_in     = '0;
         clamp_in = clamped;
      end else if (cmd.div_step) begin
         rem_in = ge ? (rem_ff - den_ff) : rem_ff;
         den_in = den_ff >> 1;
         q_in   = BW'({q_ff, ge});
      end

      cur_in   = cmd.set_bin ? q_ff : cur_ff;
      known_in = known_ff;
      if (cmd.set_bin) begin
         known_in = 1'b1;
      end else if (cmd.clr_known || cmd.clear_all) begin
         known_in = 1'b0;
      end
      on_in = on_ff;
      if (cmd.set_on) begin
         on_in = 1'b1;
      end else if (cmd.clr_on) begin
         on_in = 1'b0;
      end

      addr_in = cmd.rd_en ? rd_a : addr_ff;
      cnt_in  = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end

      diff_in = diff_ff;
      if (cmd.diff_en) begin
         diff_in = (!cmd.diff_gate || match) ? (now_ff - start_rd_ff) : '0;
      end

      tot_vld_in   = tot_vld_ff;
      start_vld_in = start_vld_ff;
      if (cmd.clear_all) begin
         tot_vld_in   = '0;
         start_vld_in = '0;
      end else begin
         if (cmd.tot_wr) begin
            tot_vld_in[addr_ff] = 1'b1;
         end
         if (start_we) begin
            start_vld_in[start_a] = 1'b1;
         end
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.out_code;
         rsp_index_in  = cmd.out_read ? bbrt_pkg::IDX_W'(addr_ff) : '0;
         rsp_time_in   = cmd.out_read ? sum : '0;
         rsp_last_in   = cmd.out_read ? (addr_ff == BW'(NB - 1)) : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= '0;
         max_ff       <= LW'(255);
         known_ff     <= 1'b0;
         on_ff        <= 1'b0;
         cur_ff       <= '0;
         tot_vld_ff   <= '0;
         start_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         known_ff     <= known_in;
         on_ff        <= on_in;
         cur_ff       <= cur_in;
         tot_vld_ff   <= tot_vld_in;
         start_vld_ff <= start_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      lvl_ff        <= lvl_in;
      pv_ff         <= pv_in;
      now_ff        <= now_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      q_ff          <= q_in;
      clamp_ff      <= clamp_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      diff_ff       <= diff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // an entry not written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (cmd.tot_wr) begin
         tot_mem[addr_ff] <= sum;
      end
      if (start_we) begin
         start_mem[start_a] <= now_ff;
      end
      if (cmd.rd_en) begin
         tot_rd_ff   <= tot_vld_ff[rd_a] ? tot_mem[rd_a] : '0;
         start_rd_ff <= start_vld_ff[rd_a] ? start_mem[rd_a] : '0;
      end
   end

   assign sts.mode       = mode_ff;
   assign sts.pv         = pv_ff;
   assign sts.panel_on   = on_ff;
   assign sts.bin_known  = known_ff;
   assign sts.bin_change = cur_ff != q_ff;
   assign sts.clamped    = clamp_ff;
   assign sts.out_free   = out_free;
   assign sts.cnt_last   = cnt_ff == BW'(NB - 1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_time_ff, rsp_index_ff, rsp_status_ff};

endmodule

`default_nettype wire
